### design/assert_macros.svh
// Assertion macros used by the sequencer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked at the following clock edge.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### design/abs_pkg.sv
// Package with the types and constants of the axis bring-up sequencer.
`timescale 1ns / 1ps
package abs_pkg;
  localparam logic [1:0] OP_FEEDBACK = 2'd0;
  localparam logic [1:0] OP_POLL     = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;

  localparam logic [3:0] ST_STOP         = 4'd0;
  localparam logic [3:0] ST_WAIT_STOPPED = 4'd1;
  localparam logic [3:0] ST_MODE         = 4'd2;
  localparam logic [3:0] ST_VELOCITY     = 4'd3;
  localparam logic [3:0] ST_ACCEL        = 4'd4;
  localparam logic [3:0] ST_CURRENT      = 4'd5;
  localparam logic [3:0] ST_HOLD         = 4'd6;
  localparam logic [3:0] ST_ENABLE       = 4'd7;
  localparam logic [3:0] ST_WAIT_RUN     = 4'd8;
  localparam logic [3:0] ST_READY        = 4'd9;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_STOP    = 3'd1;
  localparam logic [2:0] CMD_CURRENT = 3'd5;
  localparam logic [2:0] CMD_ENABLE  = 3'd7;

  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_RUNNING = 2'd2;

  localparam logic [2:0] REG_FB_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_PROBE        = 3'd1;
  localparam logic [2:0] REG_RETRY        = 3'd2;
  localparam logic [2:0] REG_INIT_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_VELOCITY     = 3'd4;
  localparam logic [2:0] REG_ACCEL        = 3'd5;
  localparam logic [2:0] REG_CURRENT      = 3'd6;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [2:0]        axis;
    logic [31:0]       now_ms;
    logic              fb_online;
    logic [1:0]        fb_mode;
    logic [7:0]        fb_faults;
    logic signed [31:0] fb_position;
    logic              fb_position_valid;
    logic              tx_ready;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [2:0]        command_axis;
    logic signed [31:0] command_value;
    logic              every_ready;
    logic              timed_out;
    logic [3:0]        served_stage;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic feedback;   // store feedback
    logic start;      // clear sequencing state
    logic sweep;      // health sweep over all axes
    logic serve;      // advance the served axis
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic active;
    logic timeout;
    logic every_ready;
  } dp_status_t;
endpackage

### design/abs_stream_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface abs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/abs_datapath.sv
// Datapath: per-axis status and sequencing state, health sweep and stage step.
`timescale 1ns / 1ps
module abs_datapath import abs_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  in_item_t   item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_item_t  result
);
  localparam int PW = (AXES > 1) ? $clog2(AXES) : 1;

  logic [15:0] feedback_timeout_ms, probe_interval_ms, retry_interval_ms;
  logic [31:0] init_timeout_ms, velocity_limit, acceleration_limit, current_limit;

  logic [3:0]  stage [AXES];
  logic        write_pending [AXES];
  logic [15:0] count_mark [AXES];
  logic [31:0] last_probe_time [AXES];
  logic [31:0] enable_time [AXES];
  logic [31:0] hold_pos [AXES];
  logic        axis_online [AXES];
  logic [1:0]  axis_mode [AXES];
  logic [7:0]  axis_faults [AXES];
  logic [31:0] axis_position [AXES];
  logic        axis_position_valid [AXES];
  logic [15:0] receive_count [AXES];
  logic [31:0] last_receive_time [AXES];
  logic [PW-1:0] serve_pointer;
  logic [31:0] start_time;
  logic        active;
  logic [AXES-1:0] healthy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_timeout_ms <= 16'd100;
      probe_interval_ms   <= 16'd100;
      retry_interval_ms   <= 16'd1000;
      init_timeout_ms     <= 32'd10000;
      velocity_limit      <= '0;
      acceleration_limit  <= '0;
      current_limit       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FB_TIMEOUT:   feedback_timeout_ms <= cfg_data[15:0];
        REG_PROBE:        probe_interval_ms <= cfg_data[15:0];
        REG_RETRY:        retry_interval_ms <= cfg_data[15:0];
        REG_INIT_TIMEOUT: init_timeout_ms <= cfg_data;
        REG_VELOCITY:     velocity_limit <= cfg_data;
        REG_ACCEL:        acceleration_limit <= cfg_data;
        REG_CURRENT:      current_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Health of every axis at the current item's time.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      healthy[i] = axis_online[i] && axis_faults[i] == 8'd0 && axis_position_valid[i] &&
                   ((item.now_ms - last_receive_time[i]) < {16'd0, feedback_timeout_ms});
    end
  end

  logic timeout_hit, sweep_ready;
  assign timeout_hit = (item.now_ms - start_time) >= init_timeout_ms;
  always_comb begin
    sweep_ready = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (stage[i] != ST_READY) sweep_ready = 1'b0;
    end
  end
  assign status.active      = active;
  assign status.timeout     = timeout_hit;
  assign status.every_ready = sweep_ready;

  // Served axis decisions.
  logic [PW-1:0] s;
  logic [3:0]  sst;
  logic        chg, probe_due;
  logic [31:0] now;
  assign s   = serve_pointer;
  assign sst = stage[s];
  assign now = item.now_ms;
  assign chg = receive_count[s] != count_mark[s];
  assign probe_due = (now - last_probe_time[s]) >= {16'd0, probe_interval_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      start_time <= '0;
      serve_pointer <= '0;
      for (int i = 0; i < AXES; i++) begin
        stage[i] <= ST_STOP; write_pending[i] <= 1'b0; count_mark[i] <= '0;
        last_probe_time[i] <= '0; enable_time[i] <= '0; hold_pos[i] <= '0;
        axis_online[i] <= 1'b0; axis_mode[i] <= '0; axis_faults[i] <= '0;
        axis_position[i] <= '0; axis_position_valid[i] <= 1'b0;
        receive_count[i] <= '0; last_receive_time[i] <= '0;
      end
    end else if (cmd.feedback) begin
      if ({1'b0, item.axis} < 4'(AXES)) begin
        axis_online[PW'(item.axis)] <= item.fb_online;
        axis_mode[PW'(item.axis)] <= item.fb_mode;
        axis_faults[PW'(item.axis)] <= item.fb_faults;
        axis_position[PW'(item.axis)] <= item.fb_position;
        axis_position_valid[PW'(item.axis)] <= item.fb_position_valid;
        receive_count[PW'(item.axis)] <= receive_count[PW'(item.axis)] + 16'd1;
        last_receive_time[PW'(item.axis)] <= item.now_ms;
      end
    end else if (cmd.start) begin
      for (int i = 0; i < AXES; i++) begin
        stage[i] <= ST_STOP; write_pending[i] <= 1'b0; count_mark[i] <= '0;
        last_probe_time[i] <= '0; enable_time[i] <= '0; hold_pos[i] <= '0;
      end
      serve_pointer <= '0;
      start_time <= item.now_ms;
      active <= 1'b1;
    end else if (cmd.sweep && !timeout_hit) begin
      // Drop sick axes, and axes in the wrong mode, to stop and promote confirmed running axes.
      // A poll past the deadline leaves every stage untouched.
      for (int i = 0; i < AXES; i++) begin
        if (stage[i] > ST_READY ||
            (stage[i] == ST_READY && (!healthy[i] || axis_mode[i] != MODE_RUNNING)) ||
            (stage[i] >= ST_MODE && stage[i] < ST_READY && (!healthy[i] ||
             (stage[i] <= ST_ENABLE && axis_mode[i] != MODE_STOPPED)))) begin
          stage[i] <= ST_STOP;
          write_pending[i] <= 1'b0;
        end else if (stage[i] == ST_WAIT_RUN && healthy[i] &&
                     axis_mode[i] == MODE_RUNNING &&
                     receive_count[i] != count_mark[i]) begin
          stage[i] <= ST_READY;
        end
      end
    end else if (cmd.serve) begin
      if (timeout_hit || sweep_ready) begin
        active <= 1'b0;
      end else begin
        if (write_pending[s]) begin
          if (chg) begin
            write_pending[s] <= 1'b0;
            if (sst < ST_READY) stage[s] <= sst + 4'd1;
          end else if (probe_due) begin
            write_pending[s] <= 1'b0;
          end
        end else begin
          case (sst)
            ST_STOP: begin
              count_mark[s] <= receive_count[s];
              if (item.tx_ready) begin
                last_probe_time[s] <= now;
                stage[s] <= ST_WAIT_STOPPED;
              end
            end
            ST_WAIT_STOPPED: begin
              if (axis_online[s] && chg && axis_mode[s] == MODE_STOPPED && healthy[s]) begin
                hold_pos[s] <= axis_position[s];
                stage[s] <= ST_MODE;
              end else if (probe_due) begin
                last_probe_time[s] <= now;
              end
            end
            ST_MODE, ST_VELOCITY, ST_ACCEL, ST_CURRENT, ST_HOLD: begin
              if (item.tx_ready) begin
                count_mark[s] <= receive_count[s];
                last_probe_time[s] <= now;
                write_pending[s] <= 1'b1;
              end
            end
            ST_ENABLE: begin
              count_mark[s] <= receive_count[s];
              if (item.tx_ready) begin
                enable_time[s] <= now;
                last_probe_time[s] <= now;
                stage[s] <= ST_WAIT_RUN;
              end
            end
            ST_WAIT_RUN, ST_READY: begin
              if (sst == ST_WAIT_RUN &&
                  (now - enable_time[s]) >= {16'd0, retry_interval_ms}) begin
                stage[s] <= ST_STOP;
              end else if (probe_due) begin
                last_probe_time[s] <= now;
              end
            end
            default: stage[s] <= ST_STOP;
          endcase
        end
        serve_pointer <= (32'(serve_pointer) + 1 >= AXES) ? '0 : serve_pointer + PW'(1);
      end
    end
  end

  // Result of the served axis, computed from the state before the serve step.
  logic [3:0] next_stage;
  always_comb begin
    result = '0;
    result.command_axis = 3'(s);
    next_stage = sst;
    if (timeout_hit) begin
      result.timed_out = 1'b1;
    end else if (sweep_ready) begin
      result.every_ready = 1'b1;
    end else if (write_pending[s]) begin
      if (chg && sst < ST_READY) next_stage = sst + 4'd1;
    end else begin
      case (sst)
        ST_STOP: if (item.tx_ready) begin
          result.command = CMD_STOP; next_stage = ST_WAIT_STOPPED;
        end
        ST_WAIT_STOPPED: begin
          if (axis_online[s] && chg && axis_mode[s] == MODE_STOPPED && healthy[s]) begin
            next_stage = ST_MODE;
          end else if (probe_due && item.tx_ready) begin
            result.command = CMD_STOP;
          end
        end
        ST_MODE, ST_VELOCITY, ST_ACCEL, ST_CURRENT, ST_HOLD: if (item.tx_ready) begin
          result.command = sst[2:0];
          case (sst)
            ST_VELOCITY: result.command_value = velocity_limit;
            ST_ACCEL:    result.command_value = acceleration_limit;
            ST_CURRENT:  result.command_value = current_limit;
            ST_HOLD:     result.command_value = hold_pos[s];
            default:     result.command_value = '0;
          endcase
        end
        ST_ENABLE: if (item.tx_ready) begin
          result.command = CMD_ENABLE; next_stage = ST_WAIT_RUN;
        end
        ST_WAIT_RUN, ST_READY: begin
          if (sst == ST_WAIT_RUN && (now - enable_time[s]) >= {16'd0, retry_interval_ms}) begin
            next_stage = ST_STOP;
          end else if (probe_due && item.tx_ready) begin
            result.command = CMD_CURRENT; result.command_value = current_limit;
          end
        end
        default: next_stage = ST_STOP;
      endcase
    end
    result.served_stage = next_stage;
  end
endmodule

### design/abs_control.sv
// Controller: accepts a request, sequences the datapath and holds the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module abs_control import abs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  abs_stream_if.sink   in_ch,
  abs_stream_if.source out_ch,
  input  dp_status_t status,
  input  out_item_t  result,
  output dp_cmd_t    cmd,
  output in_item_t   item
);
  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_SERVE, S_SEND} state_t;
  state_t state;
  logic out_valid;
  out_item_t out_data;

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  // Datapath commands follow the state.
  always_comb begin
    cmd = '0;
    cmd.feedback = in_ch.valid && in_ch.ready && in_ch.data.opcode == OP_FEEDBACK;
    cmd.start    = in_ch.valid && in_ch.ready && in_ch.data.opcode == OP_START;
    cmd.sweep    = state == S_SWEEP;
    cmd.serve    = state == S_SERVE;
  end

  // State and registered output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && out_ch.ready) out_valid <= 1'b0;
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.data;
            if (in_ch.data.opcode == OP_POLL && status.active) state <= S_SWEEP;
          end
        end
        S_SWEEP: state <= status.timeout ? S_SERVE : S_SERVE;
        S_SERVE: begin
          out_data <= result;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ch.ready)
  `ASSERT_NEXT(a_serve_gives_result, clk, rst, state == S_SERVE, out_valid)
  `ASSERT_NEXT(a_sweep_then_serve, clk, rst, state == S_SWEEP, state == S_SERVE)
endmodule

### design/axis_bringup_sequencer.sv
// Top level of the axis bring-up sequencer.
`timescale 1ns / 1ps
// A poll accepted while the sequencer is active runs the sweep and serve states,
// then its result is offered from the result register; the next request waits
// until the result register has emptied. Feedback and start return no result.
// A poll while the sequencer is inactive returns no result.
// Reset (rst, synchronous) clears all axis state, restores register defaults, idles.
module axis_bringup_sequencer import abs_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  abs_stream_if.sink   in_ch,
  abs_stream_if.source out_ch
);
  dp_cmd_t    cmd;
  dp_status_t status;
  out_item_t  result;
  in_item_t   item;

  abs_control u_control (
    .clk, .rst, .in_ch, .out_ch, .status, .result, .cmd, .item
  );

  abs_datapath #(.AXES(AXES)) u_datapath (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .item(cmd.feedback || cmd.start ? in_ch.data : item),
    .cmd, .status, .result
  );
endmodule
